// File: rtl/aes_pkg.sv
// aes-128 shared types, constants and round functions
// s-box tables are built at elaboration from the gf(2^8) inverse and the affine map
// no dependencies
package aes_pkg;

  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned BLOCK_W    = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  // payload handed from one round cell to the next
  typedef struct packed {
    cmd_e                 cmd;
    logic [BLOCK_W-1:0]   state;
    logic [BLOCK_W-1:0]   key;
  } stage_t;

  typedef logic [7:0] sbox_tbl_t [256];

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = 8'h00;
    aa  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ aa;
      aa = xtime(aa);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int unsigned n);
    logic [15:0] w;
    w = {v, v} << n;
    return w[15:8];
  endfunction

  function automatic sbox_tbl_t build_sbox(input logic inverse);
    sbox_tbl_t  tbl;
    logic [7:0] x;
    logic [7:0] b;
    logic [7:0] acc;
    logic [7:0] base;
    logic [7:0] e;
    for (int i = 0; i < 256; i++) begin
      x = 8'(i);
      if (inverse) b = rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05;
      else b = x;
      // b^254 is the field inverse, zero maps to zero
      acc  = 8'h01;
      base = b;
      e    = 8'd254;
      for (int k = 0; k < 8; k++) begin
        if (e[k]) acc = gf_mul(acc, base);
        base = gf_mul(base, base);
      end
      if (inverse) tbl[i] = acc;
      else tbl[i] = acc ^ rotl8(acc, 1) ^ rotl8(acc, 2) ^ rotl8(acc, 3)
                        ^ rotl8(acc, 4) ^ 8'h63;
    end
    return tbl;
  endfunction

  localparam sbox_tbl_t SBOX_FWD = build_sbox(1'b0);
  localparam sbox_tbl_t SBOX_INV = build_sbox(1'b1);

  function automatic logic [7:0] rcon(input int unsigned n);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 1; i < 16; i++) begin
      if (i < n) r = xtime(r);
    end
    return r;
  endfunction

  function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int unsigned i);
    return s[BLOCK_W-1-8*i -: 8];
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_shift_fwd(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(r+4*c) -: 8] = SBOX_FWD[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_shift_inv(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(r+4*c) -: 8] = SBOX_INV[get_byte(s, r + 4*((c - r + 4) % 4))];
      end
    end
    return t;
  endfunction

  function automatic logic [BLOCK_W-1:0] mix(input logic [BLOCK_W-1:0] s, input logic inverse);
    logic [BLOCK_W-1:0] t;
    logic [7:0]         acc;
    logic [7:0]         m [4];
    if (inverse) begin
      m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
    end else begin
      m[0] = 8'd2;  m[1] = 8'd3;  m[2] = 8'd1;  m[3] = 8'd1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_mul(m[(k - r + 4) % 4], get_byte(s, k + 4*c));
        end
        t[BLOCK_W-1-8*(r+4*c) -: 8] = acc;
      end
    end
    return t;
  endfunction

  // rotate then substitute the last key word, plus round constant
  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    return {SBOX_FWD[w[23:16]] ^ rc, SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]], SBOX_FWD[w[31:24]]};
  endfunction

  function automatic logic [BLOCK_W-1:0] key_fwd(input logic [BLOCK_W-1:0] p,
                                                 input logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = p[127:96] ^ sub_rot(p[31:0], rc);
    n1 = p[95:64] ^ n0;
    n2 = p[63:32] ^ n1;
    n3 = p[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [BLOCK_W-1:0] key_inv(input logic [BLOCK_W-1:0] n,
                                                 input logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = n[31:0] ^ n[63:32];
    p2 = n[63:32] ^ n[95:64];
    p1 = n[95:64] ^ n[127:96];
    p0 = n[127:96] ^ sub_rot(p3, rc);
    return {p0, p1, p2, p3};
  endfunction

endpackage

// File: rtl/aes_key_unit.sv
// key registers and last round key derivation, one schedule step per cycle
// depends on aes_pkg
module aes_key_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aes_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [aes_pkg::HALF_W-1:0]      cfg_data_i,
  output logic [aes_pkg::BLOCK_W-1:0]     key_o,
  output logic [aes_pkg::BLOCK_W-1:0]     last_key_o,
  output logic                            busy_o
);
  import aes_pkg::*;

  logic [BLOCK_W-1:0] key_q, key_d;
  logic [BLOCK_W-1:0] work_q, work_d;
  logic [7:0]         rc_q, rc_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KEY_HIGH: key_d[127:64] = cfg_data_i;
        REG_KEY_LOW:  key_d[63:0]   = cfg_data_i;
        default:      key_d = key_q;
      endcase
    end
  end

  always_comb begin
    work_d = work_q;
    rc_d   = rc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (cfg_we_i) begin
      work_d = key_d;
      rc_d   = 8'h01;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      work_d = key_fwd(work_q, rc_q);
      rc_d   = xtime(rc_q);
      cnt_d  = cnt_q + 4'd1;
      if (cnt_q == 4'(NUM_ROUNDS - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      work_q <= '0;
      rc_q   <= 8'h01;
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      key_q  <= key_d;
      work_q <= work_d;
      rc_q   <= rc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign key_o      = key_q;
  assign last_key_o = work_q;
  assign busy_o     = busy_q;

endmodule

// File: rtl/aes_round_cell.sv
// one cipher round with its own round key step, registered output
// depends on aes_pkg
module aes_round_cell #(
  parameter int unsigned ROUND = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            up_valid_i,
  input  aes_pkg::stage_t up_data_i,
  input  logic            dn_ready_i,
  output logic            ready_o,
  output logic            valid_o,
  output aes_pkg::stage_t data_o
);
  import aes_pkg::*;

  localparam logic [7:0] RC_FWD = rcon(ROUND);
  localparam logic [7:0] RC_INV = rcon(NUM_ROUNDS + 1 - ROUND);
  localparam bit         LAST   = (ROUND == NUM_ROUNDS);

  logic   valid_q;
  stage_t data_q, data_d;
  logic [BLOCK_W-1:0] ss_fwd, ss_inv, nk_fwd, nk_inv, mixed_fwd, keyed_inv;

  assign ready_o = !valid_q || dn_ready_i;

  always_comb begin
    ss_fwd    = sub_shift_fwd(up_data_i.state);
    nk_fwd    = key_fwd(up_data_i.key, RC_FWD);
    mixed_fwd = LAST ? ss_fwd : mix(ss_fwd, 1'b0);
    ss_inv    = sub_shift_inv(up_data_i.state);
    nk_inv    = key_inv(up_data_i.key, RC_INV);
    keyed_inv = ss_inv ^ nk_inv;
    data_d.cmd = up_data_i.cmd;
    if (up_data_i.cmd == CMD_DEC) begin
      data_d.state = LAST ? keyed_inv : mix(keyed_inv, 1'b1);
      data_d.key   = nk_inv;
    end else begin
      data_d.state = mixed_fwd ^ nk_fwd;
      data_d.key   = nk_fwd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/aes128_block_cipher.sv
// aes-128 encrypt/decrypt top level: key unit, input stage and ten round cells
// depends on aes_pkg, aes_key_unit, aes_round_cell
//
// usage
//   input channel: in_valid_i with command_i, block_high_i, block_low_i; a transfer
//   happens when in_valid_i is high and in_stall_o is low. command 0 encrypts, 1 decrypts
//   output channel: out_valid_o with result_high_o, result_low_o; a transfer happens
//   when out_valid_o is high and out_stall_i is low
//   config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 key high, 1 key low)
//   and cfg_data_i; writes are always taken, write only while the cipher is empty
//   the input transfer passes through one whitening stage and ten round cells, each a
//   register, before out_valid_o rises; throughput one block per cycle while neither
//   out_stall_i nor the key unit's busy flag holds the chain
//   each cell steps the round key forward (encrypt) or backward (decrypt) alongside
//   the data, so decryption starts from the last round key held in the key unit
//   after reset and after every key write the key unit derives the last round key,
//   one schedule step per cycle; in_stall_o is high meanwhile
//   when the receiver stalls, the last cell holds its result and empty cells further
//   up keep filling, so input is still taken until the whole chain is full
module aes128_block_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [63:0]                   block_high_i,
  input  logic [63:0]                   block_low_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [63:0]                   result_high_o,
  output logic [63:0]                   result_low_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                   cfg_data_i
);
  import aes_pkg::*;

  logic [BLOCK_W-1:0] key, last_key, first_key, blk;
  logic               key_busy;
  logic               accept;

  // stage 0 is the whitening register, stages 1..10 are the round cells
  logic               valid_s [NUM_ROUNDS+1];
  stage_t             data_s  [NUM_ROUNDS+1];
  logic               ready_s [NUM_ROUNDS+2];

  logic   v0_q;
  stage_t d0_q, d0_d;

  assign cfg_ready_o = 1'b1;

  aes_key_unit u_key (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key),
    .last_key_o  (last_key),
    .busy_o      (key_busy)
  );

  // input side: whitening key depends on direction
  assign ready_s[0] = !v0_q || ready_s[1];
  assign in_stall_o = key_busy || !ready_s[0];
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    blk       = {block_high_i, block_low_i};
    first_key = (cmd_e'(command_i) == CMD_DEC) ? last_key : key;
    d0_d.cmd   = cmd_e'(command_i);
    d0_d.state = blk ^ first_key;
    d0_d.key   = first_key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (ready_s[0]) begin
      v0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      d0_q <= d0_d;
    end
  end

  assign valid_s[0] = v0_q;
  assign data_s[0]  = d0_q;

  // chain of round cells
  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    aes_round_cell #(
      .ROUND (r)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (valid_s[r-1]),
      .up_data_i  (data_s[r-1]),
      .dn_ready_i (ready_s[r+1]),
      .ready_o    (ready_s[r]),
      .valid_o    (valid_s[r]),
      .data_o     (data_s[r])
    );
  end

  // output side
  assign ready_s[NUM_ROUNDS+1] = !out_stall_i;
  assign out_valid_o   = valid_s[NUM_ROUNDS];
  assign result_high_o = data_s[NUM_ROUNDS].state[127:64];
  assign result_low_o  = data_s[NUM_ROUNDS].state[63:0];

endmodule

// File: sim/tb_aes128_block_cipher.sv
// self-checking bench for the aes-128 encrypt/decrypt pipeline
// holds its own fips-197 cipher predictor; depends on aes_pkg and aes128_block_cipher
`timescale 1ns / 100ps

module tb_aes128_block_cipher;
  import aes_pkg::*;

  // cycles without a transfer on either channel before the run is declared hung
  localparam int unsigned HANG_LIMIT = 20000;
  // pipeline depth plus the key schedule warm-up after a key write
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 1344;
  localparam int unsigned HOLD_OFF_CYCLES = 200;

  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        checked; // expected value typed in below
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } vector_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [63:0] block_high_i;
  logic [63:0] block_low_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [63:0] cfg_data_i;

  aes128_block_cipher u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .block_high_i (block_high_i),
    .block_low_i  (block_low_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_high_o(result_high_o),
    .result_low_o (result_low_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // predictor's own copy of the key registers
  logic [63:0] key_hi_m;
  logic [63:0] key_lo_m;

  block_t      pending_blocks[$];
  int unsigned mismatches;
  int unsigned blocks_sent;
  int unsigned blocks_back;
  int unsigned enc_sent;
  int unsigned dec_sent;
  int unsigned key_writes;
  int unsigned idle_streak;
  // idling percentages for sender and receiver, changed per phase
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  bit          hold_off;

  // ---------------------------------------------------------------------------
  // gf(2^8) arithmetic and the byte substitution, computed rather than tabled
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = dbl(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] finv(input logic [7:0] x);
    logic [7:0] acc;
    acc = 8'h01;
    // x^254, zero stays zero
    for (int i = 0; i < 254; i++) acc = fmul(acc, x);
    return acc;
  endfunction

  function automatic logic [7:0] rol(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  logic [7:0] sbox_f[256];
  logic [7:0] sbox_r[256];

  initial begin
    logic [7:0] b;
    for (int i = 0; i < 256; i++) begin
      b = finv(8'(i));
      sbox_f[i] = b ^ rol(b, 1) ^ rol(b, 2) ^ rol(b, 3) ^ rol(b, 4) ^ 8'h63;
      b = rol(8'(i), 1) ^ rol(8'(i), 3) ^ rol(8'(i), 6) ^ 8'h05;
      sbox_r[i] = finv(b);
    end
  end

  // ---------------------------------------------------------------------------
  // cipher predictor on a byte array, byte i at row i mod 4, column i div 4
  // ---------------------------------------------------------------------------
  typedef logic [7:0] bytes16_t [16];

  function automatic void expand(output logic [7:0] rk[176]);
    logic [7:0] t[4];
    logic [7:0] rc;
    logic [7:0] first;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      rk[i]     = key_hi_m[63-8*i -: 8];
      rk[8 + i] = key_lo_m[63-8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = rk[i - 4 + j];
      if (i % 16 == 0) begin
        first = t[0];
        t[0] = sbox_f[t[1]] ^ rc;
        t[1] = sbox_f[t[2]];
        t[2] = sbox_f[t[3]];
        t[3] = sbox_f[first];
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ t[j];
    end
  endfunction

  function automatic void add_rk(inout bytes16_t s, input logic [7:0] rk[176],
                                 input int rnd);
    for (int i = 0; i < 16; i++) s[i] ^= rk[16*rnd + i];
  endfunction

  function automatic void subst_rows(inout bytes16_t s, input bit inv);
    bytes16_t t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? (c - r + 4) % 4 : (c + r) % 4;
        t[r + 4*c] = inv ? sbox_r[s[r + 4*src]] : sbox_f[s[r + 4*src]];
      end
    end
    s = t;
  endfunction

  function automatic void mix_cols(inout bytes16_t s, input bit inv);
    logic [7:0] m[4];
    bytes16_t t;
    logic [7:0] acc;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= fmul(m[(k - r + 4) % 4], s[k + 4*c]);
        t[r + 4*c] = acc;
      end
    end
    s = t;
  endfunction

  function automatic block_t aes_block(input cmd_e cmd, input logic [63:0] hi,
                                       input logic [63:0] lo);
    logic [7:0] rk[176];
    bytes16_t s;
    block_t res;
    expand(rk);
    for (int i = 0; i < 8; i++) begin
      s[i]     = hi[63-8*i -: 8];
      s[8 + i] = lo[63-8*i -: 8];
    end
    if (cmd == CMD_ENC) begin
      add_rk(s, rk, 0);
      for (int r = 1; r <= 9; r++) begin
        subst_rows(s, 1'b0);
        mix_cols(s, 1'b0);
        add_rk(s, rk, r);
      end
      subst_rows(s, 1'b0);
      add_rk(s, rk, 10);
    end else begin
      add_rk(s, rk, 10);
      subst_rows(s, 1'b1);
      for (int r = 9; r >= 1; r--) begin
        add_rk(s, rk, r);
        mix_cols(s, 1'b1);
        subst_rows(s, 1'b1);
      end
      add_rk(s, rk, 0);
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[8 + i];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus one long hold-off to back the chain up
  // ---------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_stall_i <= 1'b1;
      else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    block_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      blocks_back++;
      if (pending_blocks.size() == 0) begin
        $error("result with nothing expected: %h %h", result_high_o, result_low_o);
        mismatches++;
      end else begin
        want = pending_blocks.pop_front();
        if (result_high_o !== want.hi) begin
          $error("result_high: expected %h, got %h", want.hi, result_high_o);
          mismatches++;
        end
        if (result_low_o !== want.lo) begin
          $error("result_low: expected %h, got %h", want.lo, result_low_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: counts cycles without any transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_streak <= 0;
    else idle_streak <= idle_streak + 1;
    if (idle_streak >= HANG_LIMIT) begin
      $display("aes128_block_cipher verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus tasks
  // ---------------------------------------------------------------------------
  // one configuration transfer, only with the pipeline empty
  task automatic write_key_reg(input cfg_reg_e idx, input logic [63:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_KEY_HIGH) key_hi_m = val;
    else key_lo_m = val;
    key_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // present one block, predicting its result once the transfer is seen
  task automatic send_block(input cmd_e cmd, input logic [63:0] hi, input logic [63:0] lo,
                            input bit typed, input logic [63:0] xhi, input logic [63:0] xlo);
    block_t want;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    command_i    <= cmd;
    block_high_i <= hi;
    block_low_i  <= lo;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = aes_block(cmd, hi, lo);
    if (typed && (want.hi !== xhi || want.lo !== xlo)) begin
      // typed-in answer disagrees with the predictor itself
      $error("known answer: expected %h %h, predicted %h %h", xhi, xlo, want.hi, want.lo);
      mismatches++;
    end
    if (typed) begin
      want.hi = xhi;
      want.lo = xlo;
    end
    pending_blocks.push_back(want);
    blocks_sent++;
    if (cmd == CMD_ENC) enc_sent++;
    else dec_sent++;
    @(negedge clk_i);
  endtask

  // let the chain empty, then allow the key unit time before a key write
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_blocks(input int unsigned n);
    logic [63:0] hi;
    logic [63:0] lo;
    for (int i = 0; i < n; i++) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      // now and then an extreme pattern
      case ($urandom_range(15))
        0: hi = '0;
        1: lo = '1;
        2: begin hi = '1; lo = '1; end
        default: ;
      endcase
      send_block($urandom_range(1) ? CMD_DEC : CMD_ENC, hi, lo, 1'b0, '0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed vectors: fips-197 known answers plus extremes checked by the predictor
  // ---------------------------------------------------------------------------
  vector_t directed[] = '{
    // zero key after reset, zero block
    '{CMD_ENC, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
    '{CMD_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0},
    '{CMD_ENC, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0},
    '{CMD_DEC, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0},
    '{CMD_ENC, 64'h8000000000000000, 64'h0000000000000001, 1'b0, 64'h0, 64'h0},
    '{CMD_DEC, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0}
  };

  // fips-197 appendix c.1 key and its block, after the key write
  vector_t appendix[] = '{
    '{CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
      64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
    '{CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
      64'h0011223344556677, 64'h8899aabbccddeeff},
    '{CMD_ENC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'h0, 64'h0},
    '{CMD_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0}
  };

  initial begin
    in_valid_i     = 1'b0;
    command_i      = 1'b0;
    block_high_i   = '0;
    block_low_i    = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_KEY_HIGH;
    cfg_data_i     = '0;
    key_hi_m       = '0;
    key_lo_m       = '0;
    mismatches     = 0;
    blocks_sent    = 0;
    blocks_back    = 0;
    enc_sent       = 0;
    dec_sent       = 0;
    key_writes     = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_off       = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);

    // reset key: the key unit's warm-up shows as in_stall_o
    foreach (directed[i])
      send_block(directed[i].cmd, directed[i].hi, directed[i].lo, directed[i].checked,
                 directed[i].exp_hi, directed[i].exp_lo);
    drain();
    write_key_reg(REG_KEY_HIGH, 64'h0001020304050607);
    write_key_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    foreach (appendix[i])
      send_block(appendix[i].cmd, appendix[i].hi, appendix[i].lo, appendix[i].checked,
                 appendix[i].exp_hi, appendix[i].exp_lo);

    // back-pressure: receiver held off while the sender keeps offering
    hold_off = 1'b1;
    fork
      random_blocks(30);
      begin
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();

    // all-ones key, then random phases each with a fresh random key
    write_key_reg(REG_KEY_HIGH, '1);
    write_key_reg(REG_KEY_LOW, '1);
    random_blocks(50);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 84; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 84; end
        default: begin send_gap_pct = 21; recv_stall_pct = 21; end
      endcase
      drain();
      // a lone key register change: blocks must see the new key at once
      write_key_reg(REG_KEY_HIGH, {$urandom, $urandom});
      random_blocks(RANDOM_ITEMS / 8);
      drain();
      write_key_reg(REG_KEY_LOW, {$urandom, $urandom});
      random_blocks(RANDOM_ITEMS / 8);
    end
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    drain();
    write_key_reg(REG_KEY_HIGH, '0);
    write_key_reg(REG_KEY_LOW, '0);
    random_blocks(20);
    drain();

    $display("covered %0d blocks (%0d encrypt, %0d decrypt), %0d results, %0d key writes",
             blocks_sent, enc_sent, dec_sent, blocks_back, key_writes);
    $display("idling phases: none, sender gaps, receiver stalls, both, plus a long hold-off");
    if (mismatches == 0) begin
      $display("aes128_block_cipher verification clean");
    end else begin
      $display("aes128_block_cipher verification failed");
    end
    $finish;
  end

endmodule
